FILE: rtl/swbc_pkg.sv
// Package for the single-wire bit-per-character codec.
// Holds the transfer structs, item codes and line-character constants.
// No dependencies.
`timescale 1ns / 1ps

package swbc_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned IDX_W = $clog2(BITS_PER_BYTE);

	// Input item codes
	localparam logic [2:0] KIND_SEND    = 3'd0;
	localparam logic [2:0] KIND_DRAINED = 3'd1;
	localparam logic [2:0] KIND_RX_CHAR = 3'd2;
	localparam logic [2:0] KIND_BREAK   = 3'd3;
	localparam logic [2:0] KIND_RX_ERR  = 3'd4;

	// Result codes
	localparam logic [1:0] OUT_LINE_CHAR = 2'd0;
	localparam logic [1:0] OUT_RX_BYTE   = 2'd1;
	localparam logic [1:0] OUT_BREAK     = 2'd2;

	// Line characters and receive decode mask
	localparam logic [7:0] CHAR_ONE    = 8'hFE;
	localparam logic [7:0] CHAR_ZERO   = 8'hC0;
	localparam logic [7:0] NIBBLE_MASK = 8'hF0;

	// Configuration register indexes
	localparam logic CFG_CAPTURE_ENABLE = 1'b0;
	localparam logic CFG_GAP_INTERVAL   = 1'b1;

	localparam logic [7:0] GAP_INTERVAL_RESET = 8'd8;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_value;
		logic       gap_before;
		logic       last;
		logic       collision_seen;
	} out_item_t;

endpackage

FILE: rtl/single_wire_bit_per_char_codec.sv
// Top level of the single-wire bit-per-character codec.
// Depends on swbc_pkg for the transfer structs and codes.
`timescale 1ns / 1ps

// Usage
//   item channel (item_valid/item_ready/item): one event per transfer - a byte to
//     send, transmit drained, a received line char, a break or a receive error.
//   result channel (result_valid/result_ready/result): line characters to put
//     on the bus, decoded receive bytes and break markers; 'last' marks the
//     final result of one input item.
//   cfg_we/cfg_index/cfg_wdata: register write at a rising edge with cfg_we
//     high. Index 0 capture_enable, index 1 gap_interval. Write only when idle.
// Timing
//   An accepted item updates codec state at once and, if it yields a result,
//   loads the job register; its first result is presented the next cycle.
//   A send byte gives eight line characters, one per cycle while result_ready
//   is high; a receive byte or break marker gives a single result.
//   Items that produce no result still need a free job register to enter.
//   item_ready is high while the job register is empty or its final result is
//   being transferred, so a new item enters in the cycle the previous drains.
// Reset
//   arst_n clears all control state: transmitter idle, delayed-idle flag set,
//   no collision, receive count zero, gap counter eight, capture on, interval 8.
// Stall
//   While result_ready is low a full job register holds and item_ready drops.
module single_wire_bit_per_char_codec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  swbc_pkg::in_item_t item,
	output logic               result_valid,
	input  logic               result_ready,
	output swbc_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_wdata
);
	import swbc_pkg::*;

	// configuration
	logic       capture_enable_q;
	logic [7:0] gap_interval_q;

	// codec state
	logic                 tx_busy_q, tx_busy_d;
	logic                 delayed_tx_idle_q, delayed_tx_idle_d;
	logic                 reprocess_q, reprocess_d;
	logic                 collision_q, collision_d;
	logic [IDX_W-1:0]     rx_cnt_q, rx_cnt_d;
	logic [7:0]           rx_bits_q, rx_bits_d;
	logic [7:0]           gap_cnt_q, gap_cnt_d;

	// job register: results of one item, drained one per cycle while result_ready is high
	logic                 job_v_s1;
	logic [1:0]           job_kind_s1;
	logic [7:0]           job_val_s1;
	logic                 job_gap_s1;
	logic                 job_coll_s1;
	logic [IDX_W-1:0]     job_idx_s1;

	logic       load;
	logic [1:0] load_kind;
	logic [7:0] load_val;
	logic       load_gap;
	logic       accept;
	logic       pop;
	logic       job_last;
	logic [7:0] gap_dec;
	logic [7:0] rx_shift;

	assign accept   = item_valid & item_ready;
	assign job_last = (job_kind_s1 != OUT_LINE_CHAR) ||
	                  (job_idx_s1 == IDX_W'(BITS_PER_BYTE - 1));
	assign pop      = job_v_s1 & result_ready;
	assign item_ready = ~job_v_s1 | (result_ready & job_last);

	assign gap_dec  = gap_cnt_q - 8'd1;
	assign rx_shift = {((item.data_value & NIBBLE_MASK) == NIBBLE_MASK), rx_bits_q[7:1]};

	// next state for the item at the input
	always_comb begin
		tx_busy_d         = tx_busy_q;
		delayed_tx_idle_d = delayed_tx_idle_q;
		reprocess_d       = reprocess_q;
		collision_d       = collision_q;
		rx_cnt_d          = rx_cnt_q;
		rx_bits_d         = rx_bits_q;
		gap_cnt_d         = gap_cnt_q;
		load              = 1'b0;
		load_kind         = OUT_LINE_CHAR;
		load_val          = item.data_value;
		load_gap          = 1'b0;
		case (item.kind)
			KIND_SEND: begin
				load = 1'b1;
				if (!tx_busy_q) begin
					gap_cnt_d = gap_interval_q;
					tx_busy_d = 1'b1;
				end else if (gap_dec == 8'd0) begin
					load_gap  = 1'b1;
					gap_cnt_d = gap_interval_q;
				end else begin
					gap_cnt_d = gap_dec;
				end
			end
			KIND_DRAINED: begin
				tx_busy_d = 1'b0;
			end
			KIND_RX_CHAR: begin
				if (rx_cnt_q == IDX_W'(BITS_PER_BYTE - 1)) begin
					if (capture_enable_q && (reprocess_q || delayed_tx_idle_q)) begin
						load        = 1'b1;
						load_kind   = OUT_RX_BYTE;
						load_val    = rx_shift;
						reprocess_d = 1'b0;
					end
					delayed_tx_idle_d = ~tx_busy_q;
					rx_cnt_d          = '0;
					rx_bits_d         = '0;
				end else begin
					rx_cnt_d  = rx_cnt_q + IDX_W'(1);
					rx_bits_d = rx_shift;
				end
			end
			KIND_BREAK: begin
				if (tx_busy_q) begin
					tx_busy_d   = 1'b0;
					collision_d = 1'b1;
					reprocess_d = 1'b1;
				end
				load      = capture_enable_q;
				load_kind = OUT_BREAK;
				load_val  = '0;
				rx_cnt_d  = '0;
				rx_bits_d = '0;
			end
			KIND_RX_ERR: begin
				rx_cnt_d  = '0;
				rx_bits_d = '0;
			end
			default: begin
				// unused codes leave state alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enable_q <= 1'b1;
			gap_interval_q   <= GAP_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPTURE_ENABLE: capture_enable_q <= cfg_wdata[0];
				CFG_GAP_INTERVAL:   gap_interval_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_busy_q         <= 1'b0;
			delayed_tx_idle_q <= 1'b1;
			reprocess_q       <= 1'b0;
			collision_q       <= 1'b0;
			rx_cnt_q          <= '0;
			rx_bits_q         <= '0;
			gap_cnt_q         <= GAP_INTERVAL_RESET;
		end else if (accept) begin
			tx_busy_q         <= tx_busy_d;
			delayed_tx_idle_q <= delayed_tx_idle_d;
			reprocess_q       <= reprocess_d;
			collision_q       <= collision_d;
			rx_cnt_q          <= rx_cnt_d;
			rx_bits_q         <= rx_bits_d;
			gap_cnt_q         <= gap_cnt_d;
		end
	end

	// job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_s1   <= 1'b0;
			job_idx_s1 <= '0;
		end else if (accept && load) begin
			job_v_s1   <= 1'b1;
			job_idx_s1 <= '0;
		end else if (pop) begin
			if (job_last) begin
				job_v_s1 <= 1'b0;
			end else begin
				job_idx_s1 <= job_idx_s1 + IDX_W'(1);
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (accept && load) begin
			job_kind_s1 <= load_kind;
			job_val_s1  <= load_val;
			job_gap_s1  <= load_gap;
			job_coll_s1 <= collision_d;
		end
	end

	// result view: send bytes go out LSB first, one character per transfer
	always_comb begin
		result.out_kind       = job_kind_s1;
		result.gap_before     = job_gap_s1 & (job_idx_s1 == '0);
		result.last           = job_last;
		result.collision_seen = job_coll_s1;
		if (job_kind_s1 == OUT_LINE_CHAR) begin
			result.out_value = job_val_s1[job_idx_s1] ? CHAR_ONE : CHAR_ZERO;
		end else begin
			result.out_value = job_val_s1;
		end
	end

	assign result_valid = job_v_s1;

endmodule
